>>> hdl/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared constants, stage payload types and the month table for the
// epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

   localparam int unsigned NUM_STAGES = 11;

   localparam logic [35:0] EPOCH_LIMIT      = 36'd47650000000;
   localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
   localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
   localparam logic [12:0] BASE_YEAR        = 13'd1970;
   localparam logic [12:0] YEAR_BEFORE_BASE = 13'd1969;
   localparam logic [10:0] LEAP_BIAS        = 11'd477;   // leap counts up to 1969
   localparam logic [10:0] YEAR_1900_OFFSET = 11'd70;
   localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd4;      // 1970-01-01 was a Thursday

   // Reciprocals: floor(x / d) = (x * RECIP) >> SHIFT.
   // RECIP_675 is rounded down and needs one correction step afterwards.
   localparam logic [19:0] RECIP_675 = 20'd795364;   // 2^29 / 675
   localparam logic [19:0] RECIP_365 = 20'd735440;   // 2^28 / 365, exact
   localparam logic [21:0] RECIP_7   = 22'd2396746;  // 2^24 / 7, exact
   localparam logic [12:0] RECIP_225 = 13'd4661;     // 2^20 / 225, exact
   localparam logic [10:0] RECIP_15  = 11'd1093;     // 2^14 / 15, exact
   localparam logic [10:0] RECIP_25  = 11'd1311;     // 2^15 / 25, exact

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic                  in_ready;
      logic                  out_valid;
   } pipe_ctl_type;

   typedef struct packed {
      logic        in_range;
      logic [19:0] days;
      logic [16:0] sod;
   } split_type;

   typedef struct packed {
      logic [2:0] week_day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   typedef struct packed {
      logic        in_range;
      logic [11:0] years;
      logic [8:0]  rem;
      logic [10:0] leaps;
      logic        leap_prev;
      logic        leap_cur;
      tod_type     tod;
   } field_type;

   typedef struct packed {
      logic        valid_res;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  month_day;
      logic [3:0]  month_index;
      logic [10:0] years_since_1900;
      logic [8:0]  year_day;
      logic [2:0]  week_day;
   } result_type;

   // First day of year of each month, February 29 counted when leap is set.
   function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      case (month)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

>>> hdl/ecal_if.sv
// ----------------------------------------------------------------------------
// ecal_if
// Request and response channels of the calendar converter (valid/ready).
// ----------------------------------------------------------------------------
interface ecal_req_if;
   logic        valid;
   logic        ready;
   logic [35:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [4:0]  month_day;
   logic [3:0]  month_index;
   logic [10:0] years_since_1900;
   logic [8:0]  year_day;
   logic [2:0]  week_day;

   modport source (output valid, output valid_res, output second, output minute,
                   output hour, output month_day, output month_index,
                   output years_since_1900, output year_day, output week_day,
                   input ready);
   modport sink   (input valid, input valid_res, input second, input minute,
                   input hour, input month_day, input month_index,
                   input years_since_1900, input year_day, input week_day,
                   output ready);
endinterface

>>> hdl/ecal_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// ecal_pipe_ctrl
// Stage valid bits and per-stage load enables. A stage loads when it is empty
// or when the stage after it moves, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module ecal_pipe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 rsp_ready,
   output ecal_pkg::pipe_ctl_type ctl
);

   localparam int unsigned N = ecal_pkg::NUM_STAGES;

   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] en;

   always_comb begin
      en[N-1] = !valid_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < N; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en        = en;
   assign ctl.in_ready  = en[0];
   assign ctl.out_valid = valid_ff[N-1];

endmodule

>>> hdl/ecal_day_split.sv
// ----------------------------------------------------------------------------
// ecal_day_split
// Four stages: range check, reciprocal multiply, remainder, correction.
// Splits the seconds count into whole days and seconds of the day.
// ----------------------------------------------------------------------------
module ecal_day_split (
   input  logic                clock,
   input  logic [3:0]          stage_en,
   input  logic [35:0]         epoch_seconds,
   output ecal_pkg::split_type split
);

   // stage 1
   logic [35:0] t1_ff;
   logic        range1_ff;
   // stage 2
   logic [35:0] t2_ff;
   logic        range2_ff;
   logic [48:0] prod2_ff;
   logic [48:0] prod2_in;
   // stage 3
   logic        range3_ff;
   logic [19:0] q3_ff;
   logic [17:0] rem3_ff;
   logic [19:0] q_est;
   logic [36:0] q_secs;
   logic [36:0] rem_full;
   // stage 4
   ecal_pkg::split_type split_ff;
   ecal_pkg::split_type split_in;

   // t / 86400 == (t >> 7) / 675
   assign prod2_in = {20'd0, t1_ff[35:7]} * {29'd0, ecal_pkg::RECIP_675};

   assign q_est    = prod2_ff[48:29];
   assign q_secs   = {17'd0, q_est} * {20'd0, ecal_pkg::SECS_PER_DAY};
   assign rem_full = {1'b0, t2_ff} - q_secs;

   always_comb begin
      split_in.in_range = range3_ff;
      if (rem3_ff >= {1'b0, ecal_pkg::SECS_PER_DAY}) begin
         split_in.days = q3_ff + 20'd1;
         split_in.sod  = 17'(rem3_ff - {1'b0, ecal_pkg::SECS_PER_DAY});
      end else begin
         split_in.days = q3_ff;
         split_in.sod  = rem3_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t1_ff     <= epoch_seconds;
         range1_ff <= (epoch_seconds <= ecal_pkg::EPOCH_LIMIT);
      end
      if (stage_en[1]) begin
         t2_ff     <= t1_ff;
         range2_ff <= range1_ff;
         prod2_ff  <= prod2_in;
      end
      if (stage_en[2]) begin
         range3_ff <= range2_ff;
         q3_ff     <= q_est;
         rem3_ff   <= rem_full[17:0];
      end
      if (stage_en[3]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

>>> hdl/ecal_field_calc.sv
// ----------------------------------------------------------------------------
// ecal_field_calc
// Four stages: year estimate, day remainder, weekday, time of day, the leap
// days before the estimated year and leap flags for it and the year before it.
// ----------------------------------------------------------------------------
module ecal_field_calc (
   input  logic                clock,
   input  logic [3:0]          stage_en,
   input  ecal_pkg::split_type split,
   output ecal_pkg::field_type fields
);

   // stage 5
   logic        range5_ff;
   logic [19:0] days5_ff;
   logic [16:0] sod5_ff;
   logic [39:0] prody5_ff;
   logic [42:0] prodw5_ff;
   logic [25:0] prodh5_ff;
   logic [20:0] d4_in;
   logic [39:0] prody5_in;
   logic [42:0] prodw5_in;
   logic [25:0] prodh5_in;
   // stage 6
   logic        range6_ff;
   logic [11:0] years6_ff;
   logic [8:0]  rem6_ff;
   logic [2:0]  wd6_ff;
   logic [4:0]  hour6_ff;
   logic [11:0] soh6_ff;
   logic [11:0] years_c;
   logic [20:0] yr_days;
   logic [20:0] rem_c;
   logic [20:0] d4_6;
   logic [18:0] wq;
   logic [21:0] wq7;
   logic [21:0] wd_c;
   logic [4:0]  hour_c;
   logic [16:0] hour_secs;
   logic [16:0] soh_c;
   // stage 7
   logic        range7_ff;
   logic [11:0] years7_ff;
   logic [8:0]  rem7_ff;
   logic [2:0]  wd7_ff;
   logic [4:0]  hour7_ff;
   logic [5:0]  minute7_ff;
   logic [11:0] soh7_ff;
   logic [12:0] ym1_7_ff;
   logic [12:0] y7_ff;
   logic [10:0] q4_7_ff;
   logic [6:0]  q100_7_ff;
   logic [4:0]  q400_7_ff;
   logic [6:0]  qy100_7_ff;
   logic [12:0] ym1_c;
   logic [12:0] y_c;
   logic [21:0] p100;
   logic [19:0] p400;
   logic [21:0] py100;
   logic [20:0] pmin;
   // stage 8
   ecal_pkg::field_type fields_ff;
   ecal_pkg::field_type fields_in;
   logic [11:0] leaps_c;
   logic [13:0] r100;
   logic [13:0] ry100;
   logic [11:0] min_secs;
   logic [11:0] sec_c;

   // stage 5: reciprocal products
   assign d4_in     = {1'b0, split.days} + {18'd0, ecal_pkg::EPOCH_WEEKDAY};
   assign prody5_in = {20'd0, split.days} * {20'd0, ecal_pkg::RECIP_365};
   assign prodw5_in = {22'd0, d4_in} * {21'd0, ecal_pkg::RECIP_7};
   assign prodh5_in = {13'd0, split.sod[16:4]} * {13'd0, ecal_pkg::RECIP_225};

   // stage 6: quotients and remainders
   assign years_c   = prody5_ff[39:28];
   assign yr_days   = {9'd0, years_c} * {12'd0, ecal_pkg::DAYS_PER_YEAR};
   assign rem_c     = {1'b0, days5_ff} - yr_days;
   assign d4_6      = {1'b0, days5_ff} + {18'd0, ecal_pkg::EPOCH_WEEKDAY};
   assign wq        = prodw5_ff[42:24];
   assign wq7       = {3'd0, wq} * 22'd7;
   assign wd_c      = {1'b0, d4_6} - wq7;
   assign hour_c    = prodh5_ff[24:20];
   assign hour_secs = {12'd0, hour_c} * {5'd0, ecal_pkg::SECS_PER_HOUR};
   assign soh_c     = sod5_ff - hour_secs;

   // stage 7: year quotients by 100 and 400, minute
   assign ym1_c = {1'b0, years6_ff} + ecal_pkg::YEAR_BEFORE_BASE;
   assign y_c   = {1'b0, years6_ff} + ecal_pkg::BASE_YEAR;
   assign p100  = {11'd0, ym1_c[12:2]} * {11'd0, ecal_pkg::RECIP_25};
   assign p400  = {11'd0, ym1_c[12:4]} * {9'd0, ecal_pkg::RECIP_25};
   assign py100 = {11'd0, y_c[12:2]} * {11'd0, ecal_pkg::RECIP_25};
   assign pmin  = {11'd0, soh6_ff[11:2]} * {10'd0, ecal_pkg::RECIP_15};

   // stage 8: leap days in 1970 .. y-1, leap flags, second
   assign leaps_c  = {1'b0, q4_7_ff} - {5'd0, q100_7_ff} + {7'd0, q400_7_ff}
                     - {1'b0, ecal_pkg::LEAP_BIAS};
   assign r100     = {1'b0, ym1_7_ff} - ({7'd0, q100_7_ff} * 14'd100);
   assign ry100    = {1'b0, y7_ff} - ({7'd0, qy100_7_ff} * 14'd100);
   assign min_secs = {6'd0, minute7_ff} * 12'd60;
   assign sec_c    = soh7_ff - min_secs;

   always_comb begin
      fields_in.in_range     = range7_ff;
      fields_in.years        = years7_ff;
      fields_in.rem          = rem7_ff;
      fields_in.leaps        = leaps_c[10:0];
      // divisible by 400 == divisible by 100 with a quotient divisible by 4
      fields_in.leap_prev    = (ym1_7_ff[1:0] == 2'd0)
                               && ((r100 != 14'd0) || (q100_7_ff[1:0] == 2'd0));
      fields_in.leap_cur     = (y7_ff[1:0] == 2'd0)
                               && ((ry100 != 14'd0) || (qy100_7_ff[1:0] == 2'd0));
      fields_in.tod.week_day = wd7_ff;
      fields_in.tod.hour     = hour7_ff;
      fields_in.tod.minute   = minute7_ff;
      fields_in.tod.second   = sec_c[5:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         range5_ff <= split.in_range;
         days5_ff  <= split.days;
         sod5_ff   <= split.sod;
         prody5_ff <= prody5_in;
         prodw5_ff <= prodw5_in;
         prodh5_ff <= prodh5_in;
      end
      if (stage_en[1]) begin
         range6_ff <= range5_ff;
         years6_ff <= years_c;
         rem6_ff   <= rem_c[8:0];
         wd6_ff    <= wd_c[2:0];
         hour6_ff  <= hour_c;
         soh6_ff   <= soh_c[11:0];
      end
      if (stage_en[2]) begin
         range7_ff  <= range6_ff;
         years7_ff  <= years6_ff;
         rem7_ff    <= rem6_ff;
         wd7_ff     <= wd6_ff;
         hour7_ff   <= hour6_ff;
         minute7_ff <= pmin[19:14];
         soh7_ff    <= soh6_ff;
         ym1_7_ff   <= ym1_c;
         y7_ff      <= y_c;
         q4_7_ff    <= ym1_c[12:2];
         q100_7_ff  <= p100[21:15];
         q400_7_ff  <= p400[19:15];
         qy100_7_ff <= py100[21:15];
      end
      if (stage_en[3]) begin
         fields_ff <= fields_in;
      end
   end

   assign fields = fields_ff;

endmodule

>>> hdl/ecal_date_fix.sv
// ----------------------------------------------------------------------------
// ecal_date_fix
// Three stages: year step-back and day of year, month search over the
// month-start table, day of month and output formatting.
// ----------------------------------------------------------------------------
module ecal_date_fix (
   input  logic                 clock,
   input  logic [2:0]           stage_en,
   input  ecal_pkg::field_type  fields,
   output ecal_pkg::result_type result
);

   // stage 9
   logic              range9_ff;
   logic [11:0]       years9_ff;
   logic [8:0]        doy9_ff;
   logic              leap9_ff;
   ecal_pkg::tod_type tod9_ff;
   logic              step;
   logic [11:0]       years_c;
   logic [9:0]        rem_c;
   logic [10:0]       leaps_c;
   logic [10:0]       doy_diff;
   logic [8:0]        doy_c;
   // stage 10
   logic              range10_ff;
   logic [11:0]       years10_ff;
   logic [8:0]        doy10_ff;
   logic              leap10_ff;
   logic [3:0]        month10_ff;
   ecal_pkg::tod_type tod10_ff;
   logic [3:0]        month_c;
   // stage 11
   ecal_pkg::result_type result_ff;
   ecal_pkg::result_type result_in;
   logic [8:0]           md_c;

   // remainder short of the leap days: the day belongs to the year before
   assign step    = ({2'd0, fields.rem} < fields.leaps) && (fields.years != 12'd0);
   assign years_c = fields.years - {11'd0, step};
   assign rem_c   = {1'b0, fields.rem} + (step ? {1'b0, ecal_pkg::DAYS_PER_YEAR} : 10'd0);
   assign leaps_c = fields.leaps - {10'd0, step & fields.leap_prev};

   always_comb begin
      doy_diff = {1'b0, rem_c} - leaps_c;
      doy_c    = ({1'b0, rem_c} >= leaps_c) ? doy_diff[8:0] : 9'd0;
   end

   always_comb begin
      month_c = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy9_ff >= ecal_pkg::month_start(4'(k), leap9_ff)) begin
            month_c = month_c + 4'd1;
         end
      end
   end

   assign md_c = doy10_ff - ecal_pkg::month_start(month10_ff, leap10_ff) + 9'd1;

   always_comb begin
      result_in = '0;
      result_in.valid_res = range10_ff;
      if (range10_ff) begin
         result_in.second           = tod10_ff.second;
         result_in.minute           = tod10_ff.minute;
         result_in.hour             = tod10_ff.hour;
         result_in.month_day        = md_c[4:0];
         result_in.month_index      = month10_ff;
         result_in.years_since_1900 = years10_ff[10:0] + ecal_pkg::YEAR_1900_OFFSET;
         result_in.year_day         = doy10_ff;
         result_in.week_day         = tod10_ff.week_day;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         range9_ff <= fields.in_range;
         years9_ff <= years_c;
         doy9_ff   <= doy_c;
         leap9_ff  <= step ? fields.leap_prev : fields.leap_cur;
         tod9_ff   <= fields.tod;
      end
      if (stage_en[1]) begin
         range10_ff <= range9_ff;
         years10_ff <= years9_ff;
         doy10_ff   <= doy9_ff;
         leap10_ff  <= leap9_ff;
         month10_ff <= month_c;
         tod10_ff   <= tod9_ff;
      end
      if (stage_en[2]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> hdl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 to broken-down calendar time.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    epoch_seconds[35:0]
//   rsp_ch    out   valid/ready    valid_res, second .. week_day
//
// Eleven register stages; one request per cycle sustained while the output
// is not stalled. The last stage is the output register. A stage loads
// whenever it is empty or the next stage moves, so a stall holds only the
// requests with no empty stage ahead of them; the others move on and fill
// the empty stages. Reset clears the stage valid bits only.
//
module epoch_seconds_to_calendar_core (
   input  logic      clock,
   input  logic      reset,
   ecal_req_if.sink  req_ch,
   ecal_rsp_if.source rsp_ch
);

   ecal_pkg::pipe_ctl_type ctl;
   ecal_pkg::split_type    split;
   ecal_pkg::field_type    fields;
   ecal_pkg::result_type   result;

   ecal_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   ecal_day_split u_split (
      .clock         (clock),
      .stage_en      (ctl.en[3:0]),
      .epoch_seconds (req_ch.epoch_seconds),
      .split         (split)
   );

   ecal_field_calc u_fields (
      .clock    (clock),
      .stage_en (ctl.en[7:4]),
      .split    (split),
      .fields   (fields)
   );

   ecal_date_fix u_date (
      .clock    (clock),
      .stage_en (ctl.en[10:8]),
      .fields   (fields),
      .result   (result)
   );

   assign req_ch.ready = ctl.in_ready;

   assign rsp_ch.valid            = ctl.out_valid;
   assign rsp_ch.valid_res        = result.valid_res;
   assign rsp_ch.second           = result.second;
   assign rsp_ch.minute           = result.minute;
   assign rsp_ch.hour             = result.hour;
   assign rsp_ch.month_day        = result.month_day;
   assign rsp_ch.month_index      = result.month_index;
   assign rsp_ch.years_since_1900 = result.years_since_1900;
   assign rsp_ch.year_day         = result.year_day;
   assign rsp_ch.week_day         = result.week_day;

   // input can only back up when the whole pipe is full behind a stalled output
   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request side stalled with room in the pipe");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.valid_res) |->
         (rsp_ch.second <= 6'd59 && rsp_ch.minute <= 6'd59 && rsp_ch.hour <= 5'd23
          && rsp_ch.week_day <= 3'd6))
      else $error("time of day or weekday out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.valid_res) |->
         (rsp_ch.month_index <= 4'd11 && rsp_ch.month_day != 5'd0
          && rsp_ch.year_day <= 9'd365 && rsp_ch.years_since_1900 >= 11'd70
          && rsp_ch.years_since_1900 <= 11'd1580))
      else $error("calendar date out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.valid_res) |->
         (rsp_ch.month_day == 5'd0 && rsp_ch.years_since_1900 == 11'd0
          && rsp_ch.hour == 5'd0 && rsp_ch.week_day == 3'd0))
      else $error("out-of-range request with nonzero fields");

endmodule

>>> tb/sv/tb_epoch_seconds_to_calendar_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_core
// Feeds epoch second counts (fixed corner dates, then random times, some clustered
// around year ends and February, some out of range) through the converter under
// random backpressure and checks every response against a calendar computed here.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_core;

   localparam int unsigned RANDOM_REQUESTS = 1900;
   localparam int unsigned CALM_TAIL       = 150;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam longint unsigned INPUT_SPAN  = 64'h1000000000;   // 2^36

   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

   typedef struct {
      logic [35:0] epoch_seconds;
      bit          drain_first;   // hold off until the pipe is empty
   } pending_request_type;

   logic clock;
   logic reset;

   ecal_req_if req_if ();
   ecal_rsp_if rsp_if ();

   epoch_seconds_to_calendar_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   pending_request_type  request_q [$];
   ecal_pkg::result_type expected_calendar_q [$];

   int unsigned total_requests;
   int unsigned accepted_count;
   int unsigned received_count;
   int unsigned error_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   // leap days falling in 1970 .. yr-1
   function automatic int unsigned leap_days_since_1970(input int unsigned yr);
      int y1;
      y1 = int'(yr) - 1;
      return int'((y1 / 4 - 492) - (y1 / 100 - 19) + (y1 / 400 - 4));
   endfunction

   function automatic longint unsigned year_start_seconds(input int unsigned yr);
      longint unsigned day_num;
      day_num = longint'(yr - 1970) * 365 + leap_days_since_1970(yr);
      return day_num * 86400;
   endfunction

   function automatic ecal_pkg::result_type predict_calendar(input logic [35:0] secs);
      ecal_pkg::result_type cal;
      longint unsigned      t;
      int unsigned          day_num, yrs, leaps, rem, doy, yr, md, mon, mlen;
      bit                   done;
      cal = '0;
      if (secs > ecal_pkg::EPOCH_LIMIT) begin
         return cal;
      end
      t       = 64'(secs);
      day_num = int'(t / 86400);
      yrs     = day_num / 365;
      rem     = day_num % 365;
      leaps   = leap_days_since_1970(1970 + yrs);
      // estimate overshoots when the leap days eat into the remainder
      if (rem < leaps && yrs > 0) begin
         yrs   = yrs - 1;
         rem   = rem + 365;
         leaps = leap_days_since_1970(1970 + yrs);
      end
      doy  = (rem >= leaps) ? rem - leaps : 0;
      yr   = 1970 + yrs;
      md   = doy;
      mon  = 0;
      done = 1'b0;
      for (int k = 0; k < 12; k++) begin
         if (!done) begin
            mlen = (k == 1 && is_leap_year(yr)) ? 29 : MONTH_DAYS[k];
            if (md < mlen || k == 11) begin
               done = 1'b1;
            end else begin
               md  = md - mlen;
               mon = mon + 1;
            end
         end
      end
      cal.valid_res        = 1'b1;
      cal.second           = 6'(t % 60);
      cal.minute           = 6'((t / 60) % 60);
      cal.hour             = 5'((t / 3600) % 24);
      cal.month_day        = 5'(md + 1);
      cal.month_index      = 4'(mon);
      cal.years_since_1900 = 11'(yr - 1900);
      cal.year_day         = 9'(doy);
      cal.week_day         = 3'((day_num + 4) % 7);
      return cal;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("[%0t] ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic add_request(input longint unsigned secs, input bit drain_first);
      pending_request_type item;
      item.epoch_seconds = 36'(secs);
      item.drain_first   = drain_first;
      request_q.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      bit fire;
      bit show;
      int unsigned send_gap;
      bit          send_busy;
      if (reset) begin
         req_if.valid         <= 1'b0;
         req_if.epoch_seconds <= '0;
         send_gap  = 0;
         send_busy = 1'b1;
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) begin
            expected_calendar_q.push_back(predict_calendar(req_if.epoch_seconds));
            void'(request_q.pop_front());
            accepted_count++;
            if (accepted_count % 120 == 0) begin
               send_busy = ($urandom_range(0, 2) != 0);
            end
         end
         show = 1'b0;
         if (req_if.valid && !fire) begin
            show = 1'b1;
         end else if (request_q.size() != 0) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (request_q[0].drain_first && expected_calendar_q.size() != 0) begin
               show = 1'b0;
            end else if (send_busy && accepted_count + CALM_TAIL < total_requests &&
                         $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 10) - 1;
            end else begin
               show = 1'b1;
            end
         end
         req_if.valid <= show;
         if (show) begin
            req_if.epoch_seconds <= request_q[0].epoch_seconds;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      ecal_pkg::result_type got;
      ecal_pkg::result_type want;
      bit                   rdy;
      int unsigned          stall_gap;
      bit                   stall_busy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_gap  = 0;
         stall_busy = 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.valid_res        = rsp_if.valid_res;
            got.second           = rsp_if.second;
            got.minute           = rsp_if.minute;
            got.hour             = rsp_if.hour;
            got.month_day        = rsp_if.month_day;
            got.month_index      = rsp_if.month_index;
            got.years_since_1900 = rsp_if.years_since_1900;
            got.year_day         = rsp_if.year_day;
            got.week_day         = rsp_if.week_day;
            received_count++;
            if (received_count % 100 == 0) begin
               stall_busy = ($urandom_range(0, 2) != 0);
            end
            if (expected_calendar_q.size() == 0) begin
               report_mismatch("response with nothing pending", 1, 0);
            end else begin
               want = expected_calendar_q.pop_front();
               if (got.valid_res !== want.valid_res)
                  report_mismatch("valid_res", got.valid_res, want.valid_res);
               if (got.second !== want.second)
                  report_mismatch("second", got.second, want.second);
               if (got.minute !== want.minute)
                  report_mismatch("minute", got.minute, want.minute);
               if (got.hour !== want.hour)
                  report_mismatch("hour", got.hour, want.hour);
               if (got.month_day !== want.month_day)
                  report_mismatch("month_day", got.month_day, want.month_day);
               if (got.month_index !== want.month_index)
                  report_mismatch("month_index", got.month_index, want.month_index);
               if (got.years_since_1900 !== want.years_since_1900)
                  report_mismatch("years_since_1900", got.years_since_1900,
                                  want.years_since_1900);
               if (got.year_day !== want.year_day)
                  report_mismatch("year_day", got.year_day, want.year_day);
               if (got.week_day !== want.week_day)
                  report_mismatch("week_day", got.week_day, want.week_day);
            end
         end
         rdy = 1'b1;
         if (stall_gap != 0) begin
            stall_gap--;
            rdy = 1'b0;
         end else if (stall_busy && received_count + CALM_TAIL < total_requests &&
                      $urandom_range(0, 7) == 0) begin
            stall_gap = $urandom_range(1, 10) - 1;
            rdy = 1'b0;
         end
         rsp_if.ready <= rdy;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_epoch_seconds_to_calendar_core: errors");
         $finish;
      end
   end

   initial begin : stimulus
      longint unsigned rnd;
      longint unsigned secs;
      longint          near;
      int unsigned     yr;
      int unsigned     pick;
      reset          = 1'b1;
      total_requests = 0;
      accepted_count = 0;
      received_count = 0;
      error_count    = 0;
      cycle_count    = 0;

      // corner dates: day, hour and minute rollovers, leap days, century rules
      add_request(0, 1'b0);
      add_request(59, 1'b0);
      add_request(60, 1'b0);
      add_request(3599, 1'b0);
      add_request(3600, 1'b0);
      add_request(86399, 1'b0);
      add_request(86400, 1'b0);
      add_request(year_start_seconds(1972) + 59 * 86400 - 1, 1'b0);
      add_request(year_start_seconds(1973) - 1, 1'b0);     // last second of a leap year
      add_request(year_start_seconds(1973), 1'b0);
      add_request(year_start_seconds(2000) + 59 * 86400, 1'b0);
      add_request(year_start_seconds(2001) - 1, 1'b0);
      add_request(year_start_seconds(2001), 1'b0);
      add_request(year_start_seconds(2100) + 58 * 86400, 1'b0);  // no Feb 29 in 2100
      add_request(year_start_seconds(2100) + 59 * 86400, 1'b0);
      add_request(year_start_seconds(2400) + 59 * 86400, 1'b0);
      add_request(64'hFFFFFFFF, 1'b0);
      add_request(64'h100000000, 1'b0);
      add_request(ecal_pkg::EPOCH_LIMIT - 1, 1'b0);
      add_request(ecal_pkg::EPOCH_LIMIT, 1'b0);
      add_request(ecal_pkg::EPOCH_LIMIT + 1, 1'b0);        // first out of range
      add_request(64'hFFFFFFFFF, 1'b0);
      add_request(64'h555555555, 1'b0);
      add_request(64'hAAAAAAAAA, 1'b0);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         rnd  = {28'd0, 4'($urandom_range(0, 15)), 32'($urandom())};
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            secs = rnd % (64'(ecal_pkg::EPOCH_LIMIT) + 1);
         end else if (pick < 70) begin
            // around New Year, where the year estimate needs correcting
            yr   = $urandom_range(1970, 3480);
            near = longint'(year_start_seconds(yr)) + longint'($urandom_range(0, 6 * 86400))
                   - 3 * 86400;
            secs = (near < 0) ? 0 : 64'(near);
         end else if (pick < 88) begin
            // end of February into March
            yr   = $urandom_range(1970, 3479);
            secs = year_start_seconds(yr) + 57 * 86400 + $urandom_range(0, 3 * 86400);
         end else begin
            secs = 64'(ecal_pkg::EPOCH_LIMIT) + 1
                   + rnd % (INPUT_SPAN - 64'(ecal_pkg::EPOCH_LIMIT) - 1);
         end
         add_request(secs, (i == 0) || (i == RANDOM_REQUESTS / 2));
      end
      total_requests = request_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || expected_calendar_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * ecal_pkg::NUM_STAGES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_epoch_seconds_to_calendar_core: clean");
      end else begin
         $display("tb_epoch_seconds_to_calendar_core: errors");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/ecal_pkg.sv
hdl/ecal_if.sv
hdl/ecal_pipe_ctrl.sv
hdl/ecal_day_split.sv
hdl/ecal_field_calc.sv
hdl/ecal_date_fix.sv
hdl/epoch_seconds_to_calendar_core.sv
tb/sv/tb_epoch_seconds_to_calendar_core.sv
